// ----- design/atfb_pkg.sv -----
// shared constants and types for the api transmit frame builder
package atfb_pkg;

    localparam int POS_W = 5;
    typedef logic [POS_W-1:0] pos_t;

    // position of each byte within the byte sequence of one frame
    localparam pos_t POS_DELIM     = 5'd0;
    localparam pos_t POS_LEN_HI    = 5'd1;
    localparam pos_t POS_LEN_LO    = 5'd2;
    localparam pos_t POS_TYPE      = 5'd3;
    localparam pos_t POS_FRAME_ID  = 5'd4;
    localparam pos_t POS_DEST_MSB  = 5'd5;
    localparam pos_t POS_DEST_LSB  = 5'd12;
    localparam pos_t POS_ADDR16_HI = 5'd13;
    localparam pos_t POS_ADDR16_LO = 5'd14;
    localparam pos_t POS_OPT_HI    = 5'd15;
    localparam pos_t POS_OPT_LO    = 5'd16;
    localparam pos_t POS_DATA      = 5'd17;
    localparam pos_t POS_CSUM      = 5'd18;

    localparam logic [7:0] HDR_DELIM     = 8'h7E;
    localparam logic [7:0] HDR_TYPE      = 8'h10;
    localparam logic [7:0] HDR_FRAME_ID  = 8'h01;
    localparam logic [7:0] HDR_ADDR16_HI = 8'hFF;
    localparam logic [7:0] HDR_ADDR16_LO = 8'hFE;
    localparam logic [7:0] HDR_OPTIONS   = 8'h00;

    // frame length field counts the payload plus the fixed api fields
    localparam logic [15:0] LEN_OFFSET = 16'd14;

    typedef struct packed {
        logic [7:0] value;
        logic       summed;
        logic       frame_end;
    } byte_info_t;

endpackage

// ----- design/atfb_byte_sel.sv -----
// selects the frame byte for one sequence position
module atfb_byte_sel (
    input  atfb_pkg::pos_t      pos,
    input  logic [7:0]          data_byte,
    input  logic [63:0]         dest_address,
    input  logic [15:0]         frame_len,
    input  logic [7:0]          running_sum,
    output atfb_pkg::byte_info_t info
);
    import atfb_pkg::*;

    logic [2:0] dest_idx;
    pos_t       dest_off;

    // most significant destination byte goes first
    assign dest_off = POS_DEST_LSB - pos;
    assign dest_idx = dest_off[2:0];

    always_comb begin
        info.value     = 8'h00;
        info.summed    = 1'b1;
        info.frame_end = 1'b0;
        if (pos >= POS_DEST_MSB && pos <= POS_DEST_LSB) begin
            info.value = dest_address[{dest_idx, 3'b000} +: 8];
        end else begin
            case (pos)
                POS_DELIM: begin
                    info.value  = HDR_DELIM;
                    info.summed = 1'b0;
                end
                POS_LEN_HI: begin
                    info.value  = frame_len[15:8];
                    info.summed = 1'b0;
                end
                POS_LEN_LO: begin
                    info.value  = frame_len[7:0];
                    info.summed = 1'b0;
                end
                POS_TYPE:      info.value = HDR_TYPE;
                POS_FRAME_ID:  info.value = HDR_FRAME_ID;
                POS_ADDR16_HI: info.value = HDR_ADDR16_HI;
                POS_ADDR16_LO: info.value = HDR_ADDR16_LO;
                POS_OPT_HI:    info.value = HDR_OPTIONS;
                POS_OPT_LO:    info.value = HDR_OPTIONS;
                POS_DATA:      info.value = data_byte;
                POS_CSUM: begin
                    info.value     = ~running_sum;
                    info.summed    = 1'b0;
                    info.frame_end = 1'b1;
                end
                default: begin
                    info.value  = 8'h00;
                    info.summed = 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- design/api_transmit_frame_builder.sv -----
// top level: api transmit-request frame builder
// Takes payload words on the s_ channel and sends the framed byte stream on
// the m_ channel, one byte per word. The first word of a frame also carries
// s_payload_length and s_dest_address; they are ignored on later words. A
// length of zero is taken as one, a length above MAX_PAYLOAD as MAX_PAYLOAD.
// The first word of a frame yields 17 header bytes and the payload byte, a
// middle word yields its byte, and the last word adds the checksum byte,
// marked by m_frame_end.
// An accepted word sits in a holding register; one byte a cycle moves from
// it into the output register while that register is empty or m_ready is
// high, so the first byte reaches m_ from the holding register by way of
// the output register. Payload of middle words streams at one word per
// cycle while m_ready stays high. The next word is taken in the cycle its
// predecessor's last byte moves to the output register.
// When m_ready is low the output register holds, the holding register fills
// and s_ready drops. Reset (aresetn low, synchronous) empties both registers
// and returns the block to the start of a frame.
module api_transmit_frame_builder #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [8:0]  s_payload_length,
    input  logic [63:0] s_dest_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_frame_end
);
    import atfb_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic             hold_valid_reg, hold_valid_next;
    logic             fresh_reg, fresh_next;
    pos_t             pos_reg, pos_next;
    logic [7:0]       data_reg;
    logic [8:0]       len_reg;
    logic [63:0]      dest_reg;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [7:0]       sum_reg, sum_next;
    logic             m_valid_reg;
    logic [7:0]       m_out_byte_reg;
    logic             m_frame_end_reg;

    pos_t             eff_pos;
    int               plen;
    logic [CNT_W-1:0] rem_after;
    logic [15:0]      frame_len;
    logic             emit;
    logic             last_step;
    logic             s_fire;
    byte_info_t       info;

    always_comb begin
        plen = int'(len_reg);
        if (plen == 0) begin
            plen = 1;
        end
        if (plen > MAX_PAYLOAD) begin
            plen = MAX_PAYLOAD;
        end
    end

    assign frame_len = 16'(plen) + LEN_OFFSET;

    // a word opens a frame when no payload bytes are still due
    assign eff_pos   = fresh_reg ? ((rem_reg == '0) ? POS_DELIM : POS_DATA) : pos_reg;
    assign rem_after = ((rem_reg == '0) ? CNT_W'(plen) : rem_reg) - CNT_W'(1);

    assign emit      = hold_valid_reg && (!m_valid_reg || m_ready);
    assign last_step = (eff_pos == POS_CSUM) || (eff_pos == POS_DATA && rem_after != '0);
    assign s_ready   = !hold_valid_reg || (emit && last_step);
    assign s_fire    = s_valid && s_ready;

    atfb_byte_sel u_byte_sel (
        .pos          (eff_pos),
        .data_byte    (data_reg),
        .dest_address (dest_reg),
        .frame_len    (frame_len),
        .running_sum  (sum_reg),
        .info         (info)
    );

    always_comb begin
        hold_valid_next = hold_valid_reg;
        fresh_next      = fresh_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        sum_next        = sum_reg;
        if (emit) begin
            fresh_next = 1'b0;
            pos_next   = eff_pos + pos_t'(1);
            if (eff_pos == POS_DELIM) begin
                sum_next = 8'h00;
            end else if (eff_pos == POS_CSUM) begin
                sum_next = 8'h00;
            end else if (info.summed) begin
                sum_next = sum_reg + info.value;
            end
            if (eff_pos == POS_DATA) begin
                rem_next = rem_after;
            end
            if (last_step) begin
                hold_valid_next = 1'b0;
            end
        end
        if (s_fire) begin
            hold_valid_next = 1'b1;
            fresh_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            fresh_reg      <= 1'b0;
            pos_reg        <= POS_DELIM;
            rem_reg        <= '0;
            sum_reg        <= 8'h00;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            fresh_reg      <= fresh_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            sum_reg        <= sum_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            data_reg <= s_data_byte;
            len_reg  <= s_payload_length;
            dest_reg <= s_dest_address;
        end
        if (emit) begin
            m_out_byte_reg  <= info.value;
            m_frame_end_reg <= info.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

// ----- tb/tb_api_transmit_frame_builder.sv -----
// testbench for the api transmit-request frame builder: directed table, then random frames
`timescale 1ns / 1ps

module tb_api_transmit_frame_builder;

    import atfb_pkg::*;

    localparam int PAYLOAD_LIMIT = 256;
    localparam int RANDOM_WORDS  = 385;
    localparam int IDLE_LIMIT    = 2000;
    localparam int TAIL_CYCLES   = 30;
    localparam int NUM_DIRECTED  = 15;

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
    } frame_byte_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [8:0]  len;
        logic [63:0] addr;
        logic        has_csum;
        logic [7:0]  csum;
    } dir_row_t;

    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte      = 8'h00;
    logic [8:0]  s_payload_length = 9'd0;
    logic [63:0] s_dest_address   = 64'h0;
    logic        m_valid;
    logic        m_ready          = 1'b1;
    logic [7:0]  m_out_byte;
    logic        m_frame_end;

    // predictor state
    logic [8:0]  payload_left = 9'd0;
    logic [7:0]  frame_sum    = 8'h00;
    frame_byte_t expected_bytes [$];

    int          error_count = 0;
    int          burst_left  = 0;
    int          words_sent  = 0;
    frame_byte_t head_byte;

    logic [15:0] stall_mask = 16'hFFFF;
    int          stall_hold = 0;

    // checksum typed in only for one-byte frames that are easy to add up by hand
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{8'h00, 9'd1,   64'h0000_0000_0000_0000, 1'b1, 8'hF1},
        '{8'hFF, 9'd1,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'hFA},
        '{8'h00, 9'd0,   64'h0000_0000_0000_0000, 1'b1, 8'hF1},
        '{8'h5A, 9'd3,   64'h0123_4567_89AB_CDEF, 1'b0, 8'h00},
        '{8'hA5, 9'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00},
        '{8'h3C, 9'd511, 64'h0000_0000_0000_0000, 1'b0, 8'h00},
        '{8'h80, 9'd2,   64'h8000_0000_0000_0001, 1'b0, 8'h00},
        '{8'h01, 9'd1,   64'h0000_0000_0000_0000, 1'b0, 8'h00},
        '{8'h55, 9'd2,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 8'h00},
        '{8'hAA, 9'd256, 64'h5555_5555_5555_5555, 1'b0, 8'h00},
        '{8'h7F, 9'd1,   64'h5555_5555_5555_5555, 1'b0, 8'h00},
        '{8'hFE, 9'd4,   64'h00FF_00FF_00FF_00FF, 1'b0, 8'h00},
        '{8'h10, 9'd170, 64'hFF00_FF00_FF00_FF00, 1'b0, 8'h00},
        '{8'h7E, 9'd85,  64'h1234_5678_9ABC_DEF0, 1'b0, 8'h00},
        '{8'hC3, 9'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00}
    };

    api_transmit_frame_builder #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_payload_length (s_payload_length),
        .s_dest_address   (s_dest_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_frame_end      (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void emit_byte(input logic [7:0] value, input logic summed,
                                      input logic last);
        frame_byte_t entry;
        if (summed) begin
            frame_sum = frame_sum + value;
        end
        entry.value     = value;
        entry.frame_end = last;
        expected_bytes.push_back(entry);
    endfunction

    // expected output bytes for one accepted payload word
    function automatic void predict_frame_bytes(input logic [7:0] data, input logic [8:0] len,
                                                input logic [63:0] addr);
        logic [8:0]  eff_len;
        logic [15:0] flen;
        int          i;
        if (payload_left == 9'd0) begin
            eff_len = (len == 9'd0) ? 9'd1 : len;
            if (eff_len > PAYLOAD_LIMIT) begin
                eff_len = 9'(PAYLOAD_LIMIT);
            end
            flen      = 16'(eff_len) + LEN_OFFSET;
            frame_sum = 8'h00;
            emit_byte(HDR_DELIM, 1'b0, 1'b0);
            emit_byte(flen[15:8], 1'b0, 1'b0);
            emit_byte(flen[7:0], 1'b0, 1'b0);
            emit_byte(HDR_TYPE, 1'b1, 1'b0);
            emit_byte(HDR_FRAME_ID, 1'b1, 1'b0);
            for (i = 7; i >= 0; i--) begin
                emit_byte(addr[8*i +: 8], 1'b1, 1'b0);
            end
            emit_byte(HDR_ADDR16_HI, 1'b1, 1'b0);
            emit_byte(HDR_ADDR16_LO, 1'b1, 1'b0);
            emit_byte(HDR_OPTIONS, 1'b1, 1'b0);
            emit_byte(HDR_OPTIONS, 1'b1, 1'b0);
            payload_left = eff_len;
        end
        emit_byte(data, 1'b1, 1'b0);
        payload_left = payload_left - 9'd1;
        if (payload_left == 9'd0) begin
            emit_byte(8'hFF - frame_sum, 1'b0, 1'b1);
            frame_sum = 8'h00;
        end
    endfunction

    task automatic send_word(input logic [7:0] data, input logic [8:0] len,
                             input logic [63:0] addr);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= data;
        s_payload_length <= len;
        s_dest_address   <= addr;
        do @(posedge aclk); while (!s_ready);
        predict_frame_bytes(data, len, addr);
        burst_left--;
        words_sent++;
    endtask

    // hold the sender off until the output side has caught up
    task automatic drain_output();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_bytes.size() != 0);
    endtask

    function automatic logic [63:0] pick_address();
        case ($urandom_range(0, 9))
            0: pick_address = 64'h0;
            1: pick_address = 64'hFFFF_FFFF_FFFF_FFFF;
            default: pick_address = {$urandom(), $urandom()};
        endcase
    endfunction

    // receiver: rotating stall pattern, reloaded now and then
    always @(posedge aclk) begin
        if (stall_hold == 0) begin
            case ($urandom_range(0, 3))
                0: stall_mask <= 16'hFFFF;
                1: stall_mask <= 16'($urandom()) | 16'h0001;
                2: stall_mask <= 16'($urandom() | $urandom() | $urandom()) | 16'h0001;
                default: stall_mask <= 16'h00FF;
            endcase
            stall_hold <= $urandom_range(20, 100);
        end else begin
            stall_mask <= {stall_mask[0], stall_mask[15:1]};
            stall_hold <= stall_hold - 1;
        end
        m_ready <= stall_mask[0];
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output word: out_byte %02h frame_end %0b",
                       m_out_byte, m_frame_end);
                error_count++;
            end else begin
                head_byte = expected_bytes.pop_front();
                if (m_out_byte !== head_byte.value) begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           head_byte.value, m_out_byte);
                    error_count++;
                end
                if (m_frame_end !== head_byte.frame_end) begin
                    $error("frame_end mismatch: expected %0b, actual %0b",
                           head_byte.frame_end, m_frame_end);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          row;
        int          frame_words;
        int          pick;
        int          k;
        logic        big_done;
        logic [8:0]  len;
        logic [8:0]  junk_len;
        frame_byte_t csum_entry;

        big_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < NUM_DIRECTED; row++) begin
            send_word(directed_rows[row].data, directed_rows[row].len,
                      directed_rows[row].addr);
            if (directed_rows[row].has_csum) begin
                csum_entry       = expected_bytes.pop_back();
                csum_entry.value = directed_rows[row].csum;
                expected_bytes.push_back(csum_entry);
            end
        end
        drain_output();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (!big_done && words_sent >= 120) begin
                // one longest frame, with the length field at or above the limit
                len      = 9'($urandom_range(PAYLOAD_LIMIT, 511));
                big_done = 1'b1;
            end else if (pick < 5) begin
                len = 9'd0;
            end else if (pick < 80) begin
                len = 9'($urandom_range(1, 6));
            end else begin
                len = 9'($urandom_range(7, 40));
            end
            frame_words = (len == 9'd0) ? 1 : ((len > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : len);

            send_word(8'($urandom()), len, pick_address());
            for (k = 1; k < frame_words; k++) begin
                // length and address are noise on later words of a frame
                junk_len = 9'($urandom_range(0, 511));
                send_word(8'($urandom()), junk_len, {$urandom(), $urandom()});
            end

            if ($urandom_range(0, 9) == 0) begin
                drain_output();
            end
        end

        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- api_transmit_frame_builder.f -----
design/atfb_pkg.sv
design/atfb_byte_sel.sv
design/api_transmit_frame_builder.sv
tb/tb_api_transmit_frame_builder.sv
